>>> sv/sts_pkg.sv
`default_nettype none

package sts_pkg;

  // fixed field widths
  localparam int unsigned ACTION_W      = 2;
  localparam int unsigned ELAPSED_W     = 16;
  localparam int unsigned ITEM_INDEX_W  = 6;
  localparam int unsigned ITEM_DELAY_W  = 16;
  localparam int unsigned SHOWN_INDEX_W = 6;
  localparam int unsigned TRACK_LEN_W   = 7;
  localparam int unsigned END_MODE_W    = 2;
  localparam int unsigned CFG_INDEX_W   = 1;
  localparam int unsigned CFG_DATA_W    = 7;
  localparam int unsigned BAL_W         = 24;

  // parameter defaults
  localparam int unsigned MAX_ITEMS_DEF  = 64;
  localparam int unsigned MAX_STEPS_DEF  = 128;
  localparam int unsigned DELAY_BITS_DEF = 16;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_TRACK_LENGTH = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_END_MODE     = 1'd1;

  localparam logic [TRACK_LEN_W-1:0] TRACK_LEN_RST = 7'd1;

  // loop modes, any other code rewinds
  localparam logic [END_MODE_W-1:0] MODE_REWIND   = 2'd0;
  localparam logic [END_MODE_W-1:0] MODE_HALT     = 2'd1;
  localparam logic [END_MODE_W-1:0] MODE_PINGPONG = 2'd2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK   = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_REWIND = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOP,
    ST_EXEC,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic load_tick;
    logic load_write;
    logic load_rewind;
    logic clr_walk;
    logic step_read;
    logic step_exec;
    logic set_limit;
  } sts_cmd_t;

  typedef struct packed {
    logic bal_neg;
    logic halted;
    logic steps_at_max;
  } sts_status_t;

endpackage

`default_nettype wire

>>> sv/sts_ctrl.sv
`default_nettype none

module sts_ctrl (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [sts_pkg::ACTION_W-1:0]   action_i,
  input  wire sts_pkg::sts_status_t           status_i,
  output sts_pkg::sts_cmd_t                   cmd_o,
  output logic                                busy_o,
  output logic                                result_valid_o
);

  sts_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sts_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    busy_o         = 1'b1;
    result_valid_o = 1'b0;
    unique case (state_q)
      sts_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.clr_walk = 1'b1;
          unique case (sts_pkg::action_e'(action_i))
            sts_pkg::ACT_TICK: begin
              cmd_o.load_tick = 1'b1;
              state_d         = sts_pkg::ST_LOOP;
            end
            sts_pkg::ACT_REWIND: begin
              cmd_o.load_rewind = 1'b1;
              state_d           = sts_pkg::ST_LOOP;
            end
            sts_pkg::ACT_WRITE: begin
              cmd_o.load_write = 1'b1;
              state_d          = sts_pkg::ST_RESULT;
            end
            sts_pkg::ACT_NONE: begin
              state_d = sts_pkg::ST_RESULT;
            end
          endcase
        end
      end
      sts_pkg::ST_LOOP: begin
        // walk stops on a negative balance, a halt or the step bound
        priority if (status_i.halted || status_i.bal_neg) begin
          state_d = sts_pkg::ST_RESULT;
        end else if (status_i.steps_at_max) begin
          cmd_o.set_limit = 1'b1;
          state_d         = sts_pkg::ST_RESULT;
        end else begin
          cmd_o.step_read = 1'b1;
          state_d         = sts_pkg::ST_EXEC;
        end
      end
      sts_pkg::ST_EXEC: begin
        cmd_o.step_exec = 1'b1;
        state_d         = sts_pkg::ST_LOOP;
      end
      sts_pkg::ST_RESULT: begin
        result_valid_o = 1'b1;
        state_d        = sts_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/sts_datapath.sv
`default_nettype none

module sts_datapath #(
  parameter int unsigned MAX_ITEMS  = sts_pkg::MAX_ITEMS_DEF,
  parameter int unsigned MAX_STEPS  = sts_pkg::MAX_STEPS_DEF,
  parameter int unsigned DELAY_BITS = sts_pkg::DELAY_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire sts_pkg::sts_cmd_t                   cmd_i,
  output sts_pkg::sts_status_t                     status_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [sts_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  wire logic [sts_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  wire logic [sts_pkg::ELAPSED_W-1:0]       elapsed_ms_i,
  input  wire logic [sts_pkg::ITEM_INDEX_W-1:0]    item_index_i,
  input  wire logic                                item_is_delay_i,
  input  wire logic [sts_pkg::ITEM_DELAY_W-1:0]    item_delay_ms_i,
  output logic [sts_pkg::SHOWN_INDEX_W-1:0]        shown_index_o,
  output logic                                     shown_valid_o,
  output logic                                     done_res_o,
  output logic                                     step_limit_hit_o
);

  localparam int unsigned PW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned LW    = $clog2(MAX_ITEMS + 1);
  localparam int unsigned STW   = $clog2(MAX_STEPS + 1);
  localparam int unsigned BAL_W = sts_pkg::BAL_W;
  localparam int unsigned SUMW  = ((DELAY_BITS > BAL_W) ? DELAY_BITS : BAL_W) + 2;
  localparam int unsigned MW    = DELAY_BITS + 1;

  logic [sts_pkg::TRACK_LEN_W-1:0] track_len_q;
  logic [sts_pkg::END_MODE_W-1:0]  end_mode_q;
  logic [BAL_W-1:0]                bal_q, bal_d;
  logic [PW-1:0]                   pos_q, pos_d;
  logic [PW-1:0]                   shown_q, shown_d;
  logic                            flag_q, flag_d;
  logic                            fwd_q, fwd_d;
  logic                            halted_q, halted_d;
  logic [STW-1:0]                  steps_q, steps_d;
  logic                            limit_q, limit_d;

  logic [MW-1:0] mem [MAX_ITEMS];
  logic [MW-1:0] rd_q;

  logic [LW-1:0]   len;
  logic [PW-1:0]   len_m1;
  logic [PW-1:0]   pos_clamp;
  logic            slot_ok;
  logic [SUMW-1:0] bal_ext;
  logic [SUMW-1:0] addend;
  logic [SUMW-1:0] sum;
  logic [SUMW-BAL_W:0] sum_hi;
  logic [BAL_W-1:0] sum_sat;

  // a track length of zero acts as one, anything too large as the table size
  always_comb begin
    priority if (track_len_q == '0) begin
      len = LW'(1);
    end else if (32'(track_len_q) > MAX_ITEMS) begin
      len = LW'(MAX_ITEMS);
    end else begin
      len = LW'(track_len_q);
    end
  end

  assign len_m1    = PW'(len - LW'(1));
  assign pos_clamp = (LW'(pos_q) >= len) ? len_m1 : pos_q;
  assign slot_ok   = 32'(item_index_i) < MAX_ITEMS;

  // one shared saturating adder for tick time and delay items
  assign bal_ext = {{(SUMW-BAL_W){bal_q[BAL_W-1]}}, bal_q};
  assign addend  = cmd_i.step_exec ? (~SUMW'(rd_q[DELAY_BITS-1:0]) + SUMW'(1))
                                   : SUMW'(elapsed_ms_i);
  assign sum     = bal_ext + addend;
  assign sum_hi  = sum[SUMW-1:BAL_W-1];

  always_comb begin
    if ((&sum_hi) || !(|sum_hi)) begin
      sum_sat = sum[BAL_W-1:0];
    end else if (sum[SUMW-1]) begin
      sum_sat = {1'b1, {(BAL_W-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(BAL_W-1){1'b1}}};
    end
  end

  always_comb begin
    bal_d    = bal_q;
    pos_d    = pos_q;
    shown_d  = shown_q;
    flag_d   = flag_q;
    fwd_d    = fwd_q;
    halted_d = halted_q;
    steps_d  = steps_q;
    limit_d  = limit_q;

    if (cmd_i.clr_walk) begin
      steps_d = '0;
      limit_d = 1'b0;
    end
    if (cmd_i.set_limit) begin
      limit_d = 1'b1;
    end
    // once halted only a negative balance catches up
    if (cmd_i.load_tick && (!halted_q || bal_q[BAL_W-1])) begin
      bal_d = sum_sat;
    end
    if (cmd_i.load_rewind) begin
      bal_d    = '0;
      pos_d    = '0;
      halted_d = 1'b0;
      shown_d  = '0;
      flag_d   = 1'b0;
    end
    if (cmd_i.step_read) begin
      pos_d   = pos_clamp;
      steps_d = steps_q + STW'(1);
    end
    if (cmd_i.step_exec) begin
      if (rd_q[MW-1]) begin
        bal_d = sum_sat;
      end else begin
        shown_d = pos_q;
        flag_d  = 1'b1;
      end
      if (fwd_q) begin
        if ((LW'(pos_q) + LW'(1)) >= len) begin
          priority if (end_mode_q == sts_pkg::MODE_HALT) begin
            pos_d    = len_m1;
            halted_d = 1'b1;
          end else if (end_mode_q == sts_pkg::MODE_PINGPONG) begin
            pos_d = len_m1;
            fwd_d = 1'b0;
          end else begin
            pos_d = '0;
          end
        end else begin
          pos_d = pos_q + PW'(1);
        end
      end else begin
        if (pos_q == '0) begin
          fwd_d = 1'b1;
        end else begin
          pos_d = pos_q - PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bal_q    <= '0;
      pos_q    <= '0;
      shown_q  <= '0;
      flag_q   <= 1'b0;
      fwd_q    <= 1'b1;
      halted_q <= 1'b0;
      steps_q  <= '0;
      limit_q  <= 1'b0;
    end else begin
      bal_q    <= bal_d;
      pos_q    <= pos_d;
      shown_q  <= shown_d;
      flag_q   <= flag_d;
      fwd_q    <= fwd_d;
      halted_q <= halted_d;
      steps_q  <= steps_d;
      limit_q  <= limit_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_len_q <= sts_pkg::TRACK_LEN_RST;
      end_mode_q  <= sts_pkg::MODE_REWIND;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sts_pkg::REG_TRACK_LENGTH: track_len_q <= cfg_wdata_i[sts_pkg::TRACK_LEN_W-1:0];
        sts_pkg::REG_END_MODE:     end_mode_q  <= cfg_wdata_i[sts_pkg::END_MODE_W-1:0];
      endcase
    end
  end

  // item table
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_write && slot_ok) begin
      mem[PW'(item_index_i)] <= {item_is_delay_i, DELAY_BITS'(item_delay_ms_i)};
    end
    if (cmd_i.step_read) begin
      rd_q <= mem[pos_clamp];
    end
  end

  assign status_o.bal_neg      = bal_q[BAL_W-1];
  assign status_o.halted       = halted_q;
  assign status_o.steps_at_max = 32'(steps_q) >= MAX_STEPS;

  assign shown_index_o    = sts_pkg::SHOWN_INDEX_W'(shown_q);
  assign shown_valid_o    = flag_q;
  assign done_res_o       = halted_q;
  assign step_limit_hit_o = limit_q;

endmodule

`default_nettype wire

>>> sv/sprite_track_sequencer_core.sv
// sprite track sequencer: plays back a table of display and delay items
//
// requests: start_i with action_i is taken at a clock edge where busy_o is
// low. a tick adds elapsed_ms_i to the time balance and walks items while it
// is not negative; write item stores one table slot; rewind clears position,
// balance, halt and shown frame and then walks with no elapsed time.
// every request gives exactly one result: result_valid_o is high for one
// cycle with shown_index_o, shown_valid_o, done_res_o and step_limit_hit_o.
// the receiver cannot stall and must take the result in that cycle.
// steps: write item or an unused action goes from the accept edge directly
// to the result; tick or rewind walks at most MAX_STEPS items, each with a
// registered table read and then an update through the shared saturating
// adder. a tick while halted adds elapsed time only to a negative balance.
// busy_o stays high until the result cycle is over, so the next request is
// taken in the cycle after the result at the earliest.
// config: cfg_we_i writes cfg_wdata_i to track_length (index 0) or the end
// mode (index 1); write only while busy_o is low.
// reset: track_length 1, rewind mode, position and balance zero, forward,
// nothing shown. table contents are not cleared and must be written first.
`default_nettype none

module sprite_track_sequencer_core #(
  parameter int unsigned MAX_ITEMS  = sts_pkg::MAX_ITEMS_DEF,
  parameter int unsigned MAX_STEPS  = sts_pkg::MAX_STEPS_DEF,
  parameter int unsigned DELAY_BITS = sts_pkg::DELAY_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic [sts_pkg::ACTION_W-1:0]     action_i,
  input  wire logic [sts_pkg::ELAPSED_W-1:0]    elapsed_ms_i,
  input  wire logic [sts_pkg::ITEM_INDEX_W-1:0] item_index_i,
  input  wire logic                             item_is_delay_i,
  input  wire logic [sts_pkg::ITEM_DELAY_W-1:0] item_delay_ms_i,
  output logic                                  result_valid_o,
  output logic [sts_pkg::SHOWN_INDEX_W-1:0]     shown_index_o,
  output logic                                  shown_valid_o,
  output logic                                  done_res_o,
  output logic                                  step_limit_hit_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [sts_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  wire logic [sts_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  sts_pkg::sts_cmd_t    cmd;
  sts_pkg::sts_status_t status;

  sts_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .action_i       (action_i),
    .status_i       (status),
    .cmd_o          (cmd),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o)
  );

  sts_datapath #(
    .MAX_ITEMS  (MAX_ITEMS),
    .MAX_STEPS  (MAX_STEPS),
    .DELAY_BITS (DELAY_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .elapsed_ms_i     (elapsed_ms_i),
    .item_index_i     (item_index_i),
    .item_is_delay_i  (item_is_delay_i),
    .item_delay_ms_i  (item_delay_ms_i),
    .shown_index_o    (shown_index_o),
    .shown_valid_o    (shown_valid_o),
    .done_res_o       (done_res_o),
    .step_limit_hit_o (step_limit_hit_o)
  );

endmodule

`default_nettype wire

>>> dv/track_playback_checker.sv
`timescale 1ns / 1ps

module track_playback_checker
  import sts_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic                     busy_i,
  input  wire logic [ACTION_W-1:0]      action_i,
  input  wire logic [ELAPSED_W-1:0]     elapsed_ms_i,
  input  wire logic [ITEM_INDEX_W-1:0]  item_index_i,
  input  wire logic                     item_is_delay_i,
  input  wire logic [ITEM_DELAY_W-1:0]  item_delay_ms_i,
  input  wire logic                     result_valid_i,
  input  wire logic [SHOWN_INDEX_W-1:0] shown_index_i,
  input  wire logic                     shown_valid_i,
  input  wire logic                     done_res_i,
  input  wire logic                     step_limit_hit_i,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_INDEX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]    cfg_wdata_i,
  output int                            fail_count_o,
  output int                            outstanding_o
);

  localparam longint BAL_HI = (longint'(1) << (BAL_W - 1)) - 1;
  localparam longint BAL_LO = -(longint'(1) << (BAL_W - 1));

  typedef struct packed {
    logic [SHOWN_INDEX_W-1:0] frame;
    logic                     seen;
    logic                     done;
    logic                     limit_hit;
  } view_t;

  view_t expected_views[$];
  view_t oldest_view;
  int    mismatches = 0;

  // mirrored block state
  logic                     kind_mem  [MAX_ITEMS_DEF];
  logic [ITEM_DELAY_W-1:0]  delay_mem [MAX_ITEMS_DEF];
  logic [TRACK_LEN_W-1:0]   play_pos;
  logic signed [BAL_W-1:0]  balance;
  logic [SHOWN_INDEX_W-1:0] frame_reg;
  logic                     frame_seen;
  logic                     forward;
  logic                     stopped;
  logic [TRACK_LEN_W-1:0]   len_reg;
  logic [END_MODE_W-1:0]    mode_reg;

  assign fail_count_o = mismatches;

  function automatic int unsigned active_length();
    if (len_reg == 0) return 1;
    if (len_reg > MAX_ITEMS_DEF) return MAX_ITEMS_DEF;
    return len_reg;
  endfunction

  function automatic logic signed [BAL_W-1:0] clamp_balance(input longint v);
    if (v > BAL_HI) return BAL_HI[BAL_W-1:0];
    if (v < BAL_LO) return BAL_LO[BAL_W-1:0];
    return v[BAL_W-1:0];
  endfunction

  // walks the track, returns 1 when the per-walk step bound stopped it
  function automatic logic walk_track(input longint gained);
    int unsigned len;
    int unsigned steps;
    len = active_length();
    steps = 0;
    if (stopped) begin
      if (balance < 0) balance = clamp_balance(longint'(balance) + gained);
      return 1'b0;
    end
    balance = clamp_balance(longint'(balance) + gained);
    while (balance >= 0) begin
      if (steps >= MAX_STEPS_DEF) return 1'b1;
      steps++;
      if (play_pos >= len) play_pos = TRACK_LEN_W'(len - 1);
      if (kind_mem[play_pos[ITEM_INDEX_W-1:0]]) begin
        balance = clamp_balance(longint'(balance)
                                - longint'(delay_mem[play_pos[ITEM_INDEX_W-1:0]]));
      end else begin
        frame_reg = play_pos[SHOWN_INDEX_W-1:0];
        frame_seen = 1'b1;
      end
      if (forward) begin
        play_pos++;
        if (play_pos >= len) begin
          if (mode_reg == MODE_HALT) begin
            play_pos = TRACK_LEN_W'(len - 1);
            stopped = 1'b1;
            return 1'b0;
          end else if (mode_reg == MODE_PINGPONG) begin
            play_pos = TRACK_LEN_W'(len - 1);
            forward = 1'b0;
          end else begin
            play_pos = '0;
          end
        end
      end else if (play_pos == 0) begin
        // running out backwards turns around in every mode
        forward = 1'b1;
      end else begin
        play_pos--;
      end
    end
    return 1'b0;
  endfunction

  function automatic view_t predict_view(input action_e act,
                                         input logic [ELAPSED_W-1:0] elapsed,
                                         input logic [ITEM_INDEX_W-1:0] slot,
                                         input logic is_delay,
                                         input logic [ITEM_DELAY_W-1:0] dly);
    view_t v;
    logic  hit;
    hit = 1'b0;
    case (act)
      ACT_TICK: hit = walk_track(longint'(elapsed));
      ACT_WRITE: begin
        kind_mem[slot]  = is_delay;
        delay_mem[slot] = dly;
      end
      ACT_REWIND: begin
        balance    = '0;
        play_pos   = '0;
        stopped    = 1'b0;
        frame_reg  = '0;
        frame_seen = 1'b0;
        hit = walk_track(0);
      end
      default: ;
    endcase
    v.frame     = frame_reg;
    v.seen      = frame_seen;
    v.done      = stopped;
    v.limit_hit = hit;
    return v;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_views.delete();
      play_pos      = '0;
      balance       = '0;
      frame_reg     = '0;
      frame_seen    = 1'b0;
      forward       = 1'b1;
      stopped       = 1'b0;
      len_reg       = TRACK_LEN_RST;
      mode_reg      = MODE_REWIND;
      outstanding_o <= 0;
    end else begin
      if (result_valid_i) begin
        if (expected_views.size() == 0) begin
          $error("result with no request pending: shown_index %0d", shown_index_i);
          mismatches++;
        end else begin
          oldest_view = expected_views.pop_front();
          check_field("shown_index", 16'(oldest_view.frame), 16'(shown_index_i));
          check_field("shown_valid", 16'(oldest_view.seen), 16'(shown_valid_i));
          check_field("done_res", 16'(oldest_view.done), 16'(done_res_i));
          check_field("step_limit_hit", 16'(oldest_view.limit_hit), 16'(step_limit_hit_i));
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_TRACK_LENGTH: len_reg = cfg_wdata_i[TRACK_LEN_W-1:0];
          REG_END_MODE:     mode_reg = cfg_wdata_i[END_MODE_W-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        expected_views.insert(expected_views.size(),
                              predict_view(action_e'(action_i), elapsed_ms_i,
                                           item_index_i, item_is_delay_i,
                                           item_delay_ms_i));
      end
      outstanding_o <= expected_views.size();
    end
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import sts_pkg::*;

  localparam int unsigned CLK_PERIOD_NS  = 4;
  localparam int unsigned RESET_CYCLES   = 5;
  localparam longint      TIMEOUT_NS     = 6_000_000;
  localparam int unsigned SEGMENT_ITEMS  = 90;
  localparam int unsigned ITEM_TARGET    = 1150;
  localparam int unsigned CFG_SETTLE     = 4;
  localparam int unsigned END_SETTLE     = 2 * MAX_STEPS_DEF + 8;
  localparam int unsigned SATURATE_TICKS = 136;
  localparam logic [END_MODE_W-1:0] MODE_SPARE = 2'd3;

  logic                     clk_i           = 1'b0;
  logic                     rst_ni          = 1'b0;
  logic                     start_i         = 1'b0;
  logic [ACTION_W-1:0]      action_i        = '0;
  logic [ELAPSED_W-1:0]     elapsed_ms_i    = '0;
  logic [ITEM_INDEX_W-1:0]  item_index_i    = '0;
  logic                     item_is_delay_i = 1'b0;
  logic [ITEM_DELAY_W-1:0]  item_delay_ms_i = '0;
  logic                     cfg_we_i        = 1'b0;
  logic [CFG_INDEX_W-1:0]   cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0]    cfg_wdata_i     = '0;
  logic                     busy_o;
  logic                     result_valid_o;
  logic [SHOWN_INDEX_W-1:0] shown_index_o;
  logic                     shown_valid_o;
  logic                     done_res_o;
  logic                     step_limit_hit_o;

  int fail_count;
  int outstanding;
  int unsigned idle_pct  = 38;
  int unsigned sent_items = 0;
  int unsigned ticks = 0, writes = 0, rewinds = 0, noops = 0, reg_writes = 0;
  int unsigned seg;

  sprite_track_sequencer_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .action_i         (action_i),
    .elapsed_ms_i     (elapsed_ms_i),
    .item_index_i     (item_index_i),
    .item_is_delay_i  (item_is_delay_i),
    .item_delay_ms_i  (item_delay_ms_i),
    .result_valid_o   (result_valid_o),
    .shown_index_o    (shown_index_o),
    .shown_valid_o    (shown_valid_o),
    .done_res_o       (done_res_o),
    .step_limit_hit_o (step_limit_hit_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  track_playback_checker chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .action_i         (action_i),
    .elapsed_ms_i     (elapsed_ms_i),
    .item_index_i     (item_index_i),
    .item_is_delay_i  (item_is_delay_i),
    .item_delay_ms_i  (item_delay_ms_i),
    .result_valid_i   (result_valid_o),
    .shown_index_i    (shown_index_o),
    .shown_valid_i    (shown_valid_o),
    .done_res_i       (done_res_o),
    .step_limit_hit_i (step_limit_hit_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .fail_count_o     (fail_count),
    .outstanding_o    (outstanding)
  );

  always #(CLK_PERIOD_NS / 2) clk_i = ~clk_i;

  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  // returns at the edge that takes the request, start left high
  task automatic send_request(input action_e act, input logic [ELAPSED_W-1:0] elapsed,
                              input logic [ITEM_INDEX_W-1:0] slot, input logic is_delay,
                              input logic [ITEM_DELAY_W-1:0] dly);
    // each idle cycle is drawn on its own
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i         <= 1'b1;
    action_i        <= act;
    elapsed_ms_i    <= elapsed;
    item_index_i    <= slot;
    item_is_delay_i <= is_delay;
    item_delay_ms_i <= dly;
    do @(posedge clk_i); while (busy_o);
    case (act)
      ACT_TICK:   ticks++;
      ACT_WRITE:  writes++;
      ACT_REWIND: rewinds++;
      default:    noops++;
    endcase
    sent_items++;
  endtask

  task automatic tick(input logic [ELAPSED_W-1:0] elapsed);
    send_request(ACT_TICK, elapsed, '0, 1'b0, '0);
  endtask

  task automatic write_slot(input logic [ITEM_INDEX_W-1:0] slot, input logic is_delay,
                            input logic [ITEM_DELAY_W-1:0] dly);
    send_request(ACT_WRITE, '0, slot, is_delay, dly);
  endtask

  task automatic rewind();
    send_request(ACT_REWIND, '0, '0, 1'b0, '0);
  endtask

  // hold off until every pending request has its result
  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    reg_writes++;
  endtask

  task automatic apply_setting(input logic [TRACK_LEN_W-1:0] len,
                               input logic [END_MODE_W-1:0] mode);
    drain();
    repeat (CFG_SETTLE) @(posedge clk_i);
    write_register(REG_TRACK_LENGTH, CFG_DATA_W'(len));
    write_register(REG_END_MODE, CFG_DATA_W'(mode));
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [ELAPSED_W-1:0] pick_elapsed();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 60) return ELAPSED_W'($urandom_range(3000));
    return ELAPSED_W'($urandom);
  endfunction

  function automatic logic [ITEM_DELAY_W-1:0] pick_delay();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return '0;
    if (r < 25) return '1;
    if (r < 75) return ITEM_DELAY_W'($urandom_range(2000, 1));
    return ITEM_DELAY_W'($urandom);
  endfunction

  function automatic logic [TRACK_LEN_W-1:0] segment_length(input int unsigned n);
    case (n % 8)
      0: return 7'd64;
      1: return 7'd1;
      2: return 7'd127;
      3: return 7'd0;
      4: return 7'd2;
      5: return TRACK_LEN_W'($urandom_range(64, 3));
      6: return TRACK_LEN_W'($urandom_range(126, 65));
      default: return TRACK_LEN_W'($urandom);
    endcase
  endfunction

  // every slot gets content so no walk can read an empty entry
  task automatic program_track(input logic displays_only);
    for (int s = 0; s < MAX_ITEMS_DEF; s++) begin
      send_request(ACT_WRITE, ELAPSED_W'($urandom), ITEM_INDEX_W'(s),
                   displays_only ? 1'b0 : 1'(^$urandom_range(3)), pick_delay());
    end
  endtask

  task automatic random_request();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) begin
      send_request(ACT_TICK, pick_elapsed(), ITEM_INDEX_W'($urandom), 1'($urandom),
                   ITEM_DELAY_W'($urandom));
    end else if (r < 85) begin
      send_request(ACT_WRITE, ELAPSED_W'($urandom), ITEM_INDEX_W'($urandom),
                   1'($urandom), pick_delay());
    end else if (r < 94) begin
      send_request(ACT_REWIND, ELAPSED_W'($urandom), ITEM_INDEX_W'($urandom),
                   1'($urandom), ITEM_DELAY_W'($urandom));
    end else begin
      send_request(ACT_NONE, ELAPSED_W'($urandom), ITEM_INDEX_W'($urandom),
                   1'($urandom), ITEM_DELAY_W'($urandom));
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: one item, rewind mode
    send_request(ACT_NONE, '1, '1, 1'b1, '1);
    write_slot(6'd0, 1'b0, '0);
    tick('0);                           // display only track runs into the step bound
    write_slot(6'd1, 1'b1, 16'd1000);
    write_slot(6'd2, 1'b0, '0);
    write_slot(6'd3, 1'b1, 16'd3000);
    write_slot(6'd63, 1'b1, '1);

    apply_setting(7'd4, MODE_HALT);
    rewind();
    tick(16'd500);                      // still negative, no walk
    tick(16'd1500);                     // halts with negative balance
    tick(16'd1000);                     // halted, negative catches up
    tick('1);
    tick(16'd9);                        // halted and positive: nothing moves

    apply_setting(7'd4, MODE_PINGPONG);
    rewind();
    tick(16'd6000);
    tick('1);

    // shortened track and the spare mode code
    apply_setting(7'd2, MODE_SPARE);
    tick(16'd1500);
    tick('1);
    rewind();

    apply_setting(7'd0, MODE_REWIND);
    tick(16'd7);
    rewind();
    write_slot(6'd0, 1'b1, 16'd1);
    tick('1);

    program_track(1'b0);
    seg = 0;
    while (sent_items < ITEM_TARGET) begin
      if (sent_items < ITEM_TARGET / 3) begin
        idle_pct = 38;
      end else if (sent_items < 2 * ITEM_TARGET / 3) begin
        idle_pct = 75;
      end else if (idle_pct != 0) begin
        idle_pct = 0;
        // drive the balance into its upper limit on an all-display track
        apply_setting(7'd64, MODE_REWIND);
        program_track(1'b1);
        repeat (SATURATE_TICKS) tick('1);
        rewind();
        program_track(1'b0);
      end
      apply_setting(segment_length(seg), END_MODE_W'((seg + seg / 8) % 4));
      for (int n = 0; n < SEGMENT_ITEMS && sent_items < ITEM_TARGET; n++) begin
        random_request();
        if ($urandom_range(199) == 0) drain();
      end
      seg++;
    end

    drain();
    repeat (END_SETTLE) @(posedge clk_i);
    $display("run covered %0d requests: %0d ticks, %0d item writes, %0d rewinds,",
             ticks + writes + rewinds + noops, ticks, writes, rewinds);
    $display("%0d unused codes, %0d register writes over all loop modes and lengths 0 to 127",
             noops, reg_writes);
    if (fail_count == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
